/* design/rlcc_pkg.sv */
// ----------------------------------------------------------------------------
// rlcc_pkg: shared types and constants for the render level cap calibrator
// Verdict codes, state encoding, field widths and the constant multipliers
// used by the bit-serial rate comparators.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcc_pkg;

  localparam int LEVEL_W = 4;
  localparam int COUNT_W = 32;
  localparam int VERD_W  = 3;
  localparam int STREAK_W = 2;

  // serial products are at most 32 + 9 bits; one spare bit flushes the carry
  localparam int SER_BITS = 42;
  localparam int CNT_W    = 6;
  localparam int MUL_W    = 10;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_TOO_SHORT = 3'd0,
    VERDICT_BAD       = 3'd1,
    VERDICT_CLEAN     = 3'd2,
    VERDICT_RAISED    = 3'd3,
    VERDICT_HELD      = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // result of an LSB-first serial compare of a*ma against b*mb
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_flags_t;

  localparam logic [COUNT_W-1:0] MIN_SECONDS = 32'd60;
  localparam logic [COUNT_W-1:0] MIN_PACED   = 32'd1800;
  localparam logic [LEVEL_W-1:0] LOWEST_CAP  = 4'd2;

  // floor(x*1000/p) >= k  <=>  x*1000 >= k*p, reduced by the common factor
  localparam logic [MUL_W-1:0] LATE_BAD_X   = 10'd100; // late rate >= 30 per mille
  localparam logic [MUL_W-1:0] LATE_BAD_P   = 10'd3;
  localparam logic [MUL_W-1:0] LATE_CLN_X   = 10'd200; // late rate < 5 per mille
  localparam logic [MUL_W-1:0] SKIP_BAD_X   = 10'd50;  // skip rate >= 20 per mille
  localparam logic [MUL_W-1:0] SKIP_CLN_X   = 10'd500; // skip rate < 2 per mille
  localparam logic [MUL_W-1:0] DROP_X       = 10'd60;
  localparam logic [MUL_W-1:0] UNITY        = 10'd1;

endpackage

`default_nettype wire

/* design/rlcc_ser_cmp.sv */
// ----------------------------------------------------------------------------
// rlcc_ser_cmp: bit-serial constant multiply and compare
// Takes two operands LSB first, scales each by a small constant with a
// running carry and compares the two product streams bit by bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcc_ser_cmp
  import rlcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             step,
  input  wire logic             a_bit,
  input  wire logic             b_bit,
  input  wire logic [MUL_W-1:0] a_mul,
  input  wire logic [MUL_W-1:0] b_mul,
  output cmp_flags_t            flags
);

  logic [MUL_W-1:0] carry_a;
  logic [MUL_W-1:0] carry_b;
  logic [MUL_W:0]   acc_a;
  logic [MUL_W:0]   acc_b;
  logic             pa;
  logic             pb;

  always_comb begin
    acc_a = {1'b0, carry_a} + (a_bit ? {1'b0, a_mul} : '0);
    acc_b = {1'b0, carry_b} + (b_bit ? {1'b0, b_mul} : '0);
    pa    = acc_a[0];
    pb    = acc_b[0];
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      carry_a  <= '0;
      carry_b  <= '0;
      flags.lt <= 1'b0;
      flags.eq <= 1'b1;
    end else if (step) begin
      carry_a <= acc_a[MUL_W:1];
      carry_b <= acc_b[MUL_W:1];
      // a higher differing bit overrides whatever the lower bits decided
      if (pa != pb) begin
        flags.lt <= pb;
      end
      flags.eq <= flags.eq & (pa == pb);
    end
  end

endmodule

`default_nettype wire

/* design/render_level_cap_calibrator_top.sv */
// ----------------------------------------------------------------------------
// render_level_cap_calibrator_top: session grading and level cap tracking
// Grades each session report by late, skip and drop rates with bit-serial
// comparators and updates the level cap and clean-session streak.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_axis  | in  | s_tdata: run_level, paced, late, skipped, dropped, seconds, rule
//  m_axis  | out | m_tdata: verdict, level_cap
//
//  A graded report is loaded from the beat, runs 42 serial bit steps
//  through five comparators (product width plus a flush bit) and then
//  commits in the finish state. A too-short report skips the serial run.
//  One report in flight; the next beat is taken while a result waits.
//  rst clears the cap to none and the streak to zero.
//  A stalled result holds the commit stage until the master side takes it.
`default_nettype none

module render_level_cap_calibrator_top
  import rlcc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // [3:0] run_level, [35:4] paced_frames, [67:36] late_frames,
  // [99:68] skipped_frames, [131:100] dropped_frames,
  // [163:132] session_seconds, [167:164] rule_level
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // [2:0] verdict, [6:3] level_cap, [7] zero
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  state_t state, state_next;

  logic [LEVEL_W-1:0]  in_level;
  logic [COUNT_W-1:0]  in_paced;
  logic [COUNT_W-1:0]  in_late;
  logic [COUNT_W-1:0]  in_skip;
  logic [COUNT_W-1:0]  in_drops;
  logic [COUNT_W-1:0]  in_secs;
  logic [LEVEL_W-1:0]  in_rule;
  logic                in_short;
  logic                accept;

  logic [COUNT_W-1:0]  paced_sr, late_sr, skip_sr, drops_sr, secs_sr;
  logic [LEVEL_W-1:0]  run_level, rule_level;
  logic                too_short, drops_zero;
  logic [CNT_W-1:0]    bit_cnt;
  logic                last_bit;
  logic                step;
  logic                commit;

  logic [LEVEL_W-1:0]  cap_level, cap_next;
  logic [STREAK_W-1:0] clean_streak, streak_next;
  verdict_t            verdict_next;

  cmp_flags_t late_bad_f, late_cln_f, skip_bad_f, skip_cln_f, drop_f;

  logic                bad, clean, eligible;
  logic [LEVEL_W-1:0]  down;
  logic [STREAK_W-1:0] streak_inc;

  assign in_level = s_tdata[3:0];
  assign in_paced = s_tdata[35:4];
  assign in_late  = s_tdata[67:36];
  assign in_skip  = s_tdata[99:68];
  assign in_drops = s_tdata[131:100];
  assign in_secs  = s_tdata[163:132];
  assign in_rule  = s_tdata[167:164];
  assign in_short = (in_secs < MIN_SECONDS) || (in_paced < MIN_PACED) ||
                    (in_level < LOWEST_CAP);

  assign last_bit = (bit_cnt == CNT_W'(SER_BITS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = in_short ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_bit) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs; no beat is taken while held in reset
  always_comb begin
    s_tready = 1'b0;
    step     = 1'b0;
    commit   = 1'b0;
    case (state)
      ST_IDLE:   s_tready = !rst;
      ST_RUN:    step     = 1'b1;
      ST_FINISH: commit   = !m_tvalid || m_tready;
      default:   s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand shift lines, zero filled behind the LSB
  always_ff @(posedge clk) begin
    if (accept) begin
      paced_sr   <= in_paced;
      late_sr    <= in_late;
      skip_sr    <= in_skip;
      drops_sr   <= in_drops;
      secs_sr    <= in_secs;
      run_level  <= in_level;
      rule_level <= in_rule;
      too_short  <= in_short;
      drops_zero <= (in_drops == '0);
    end else if (step) begin
      paced_sr <= paced_sr >> 1;
      late_sr  <= late_sr >> 1;
      skip_sr  <= skip_sr >> 1;
      drops_sr <= drops_sr >> 1;
      secs_sr  <= secs_sr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (accept) begin
      bit_cnt <= '0;
    end else if (step) begin
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
  end

  rlcc_ser_cmp u_late_bad (
    .clk(clk), .clr(accept), .step(step),
    .a_bit(late_sr[0]), .b_bit(paced_sr[0]),
    .a_mul(LATE_BAD_X), .b_mul(LATE_BAD_P), .flags(late_bad_f)
  );

  rlcc_ser_cmp u_late_cln (
    .clk(clk), .clr(accept), .step(step),
    .a_bit(late_sr[0]), .b_bit(paced_sr[0]),
    .a_mul(LATE_CLN_X), .b_mul(UNITY), .flags(late_cln_f)
  );

  rlcc_ser_cmp u_skip_bad (
    .clk(clk), .clr(accept), .step(step),
    .a_bit(skip_sr[0]), .b_bit(paced_sr[0]),
    .a_mul(SKIP_BAD_X), .b_mul(UNITY), .flags(skip_bad_f)
  );

  rlcc_ser_cmp u_skip_cln (
    .clk(clk), .clr(accept), .step(step),
    .a_bit(skip_sr[0]), .b_bit(paced_sr[0]),
    .a_mul(SKIP_CLN_X), .b_mul(UNITY), .flags(skip_cln_f)
  );

  rlcc_ser_cmp u_drop (
    .clk(clk), .clr(accept), .step(step),
    .a_bit(drops_sr[0]), .b_bit(secs_sr[0]),
    .a_mul(DROP_X), .b_mul(UNITY), .flags(drop_f)
  );

  // grading and cap update, valid in the finish state
  always_comb begin
    bad        = !late_bad_f.lt || !skip_bad_f.lt || (!drop_f.lt && !drop_f.eq);
    clean      = late_cln_f.lt && skip_cln_f.lt && drops_zero;
    eligible   = clean && (cap_level >= LOWEST_CAP) && (run_level >= cap_level) &&
                 (cap_level < rule_level);
    down       = (run_level <= LOWEST_CAP + LEVEL_W'(1)) ? LOWEST_CAP
                                                          : run_level - LEVEL_W'(1);
    streak_inc = clean_streak + STREAK_W'(1);

    cap_next     = cap_level;
    streak_next  = clean_streak;
    verdict_next = VERDICT_TOO_SHORT;
    if (!too_short) begin
      if (bad) begin
        if (cap_level == '0 || down < cap_level) begin
          cap_next = down;
        end
        streak_next  = '0;
        verdict_next = VERDICT_BAD;
      end else if (eligible) begin
        if (streak_inc >= STREAK_W'(2)) begin
          cap_next     = cap_level + LEVEL_W'(1);
          streak_next  = '0;
          verdict_next = VERDICT_RAISED;
        end else begin
          streak_next  = streak_inc;
          verdict_next = VERDICT_CLEAN;
        end
      end else begin
        streak_next  = '0;
        verdict_next = clean ? VERDICT_CLEAN : VERDICT_HELD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_level    <= '0;
      clean_streak <= '0;
    end else if (commit) begin
      cap_level    <= cap_next;
      clean_streak <= streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {1'b0, cap_next, verdict_next};
    end
  end

`ifndef SYNTHESIS
  // the cap is either none or at least the lowest level
  assert property (@(posedge clk) disable iff (rst) cap_level != LEVEL_W'(1))
    else $error("level cap took the value one");

  // a streak of two always turns into a raise and clears
  assert property (@(posedge clk) disable iff (rst) clean_streak < STREAK_W'(2))
    else $error("clean streak left at two or more");

  // cap and streak move only when a result is committed
  assert property (@(posedge clk) disable iff (rst)
                   !commit |=> $stable(cap_level) && $stable(clean_streak))
    else $error("cap state changed outside commit");

  // a raised verdict means the cap went up by exactly one
  assert property (@(posedge clk) disable iff (rst)
                   commit && verdict_next == VERDICT_RAISED |=>
                   cap_level == $past(cap_level) + LEVEL_W'(1))
    else $error("raise did not step the cap by one");

  // the serial run never overruns its bit count
  assert property (@(posedge clk) disable iff (rst)
                   bit_cnt <= CNT_W'(SER_BITS - 1) || state != ST_RUN)
    else $error("serial bit counter overran");
`endif

endmodule

`default_nettype wire
